>>> hdl/gtn_pkg.sv
package gtn_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 10;
    localparam int MIN_W    = 20;
    localparam int HOUT_W   = 5;
    localparam int MOUT_W   = 6;
    localparam int DNUM_W   = 21;
    localparam int HTOT_W   = 15;
    localparam int DAYS_W   = 22;
    localparam int YACC_W   = 13;

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

    // x / 15 for x below 2^18
    localparam logic [18:0] DIV15_MUL   = 19'd279621;
    localparam int          DIV15_SHIFT = 22;
    // x / 3 for x below 2^12
    localparam logic [11:0] DIV3_MUL    = 12'd2731;
    localparam int          DIV3_SHIFT  = 13;
    // x / 25 for x below 2^12
    localparam logic [10:0] DIV25_MUL   = 11'd1311;
    localparam int          DIV25_SHIFT = 15;
    // day number to year estimate, 2^24 / 365.2425
    localparam logic [15:0] EST_MUL     = 16'd45934;
    localparam int          EST_SHIFT   = 24;

    typedef logic [8:0] doy_t;

    function automatic doy_t month_start(input logic [MONTH_W-1:0] m, input logic leap);
        doy_t r;
        unique case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            default: r = 9'd334;
        endcase
        if (leap && m >= 4'd2)
        begin
            r = r + 9'd1;
        end
        return r;
    endfunction

endpackage

>>> hdl/gtn_days_before.sv
module gtn_days_before (
    input  logic [gtn_pkg::YACC_W-1:0]  y,
    output logic [gtn_pkg::DAYS_W-1:0]  days,
    output logic                        leap
);
    localparam int YW = gtn_pkg::YACC_W;
    localparam int DW = gtn_pkg::DAYS_W;

    logic [YW:0]   y100;
    logic [YW:0]   y400;
    logic [YW-2:0] q4;
    logic [8:0]    q100;
    logic [8:0]    q400;

    assign y100 = {1'b0, y} + (YW+1)'(99);
    assign y400 = {1'b0, y} + (YW+1)'(399);
    assign q4   = (YW-1)'(({1'b0, y} + (YW+1)'(3)) >> 2);
    assign q100 = 9'((23'(y100[YW:2]) * 23'(gtn_pkg::DIV25_MUL)) >> gtn_pkg::DIV25_SHIFT);
    assign q400 = 9'((23'(y400[YW:4]) * 23'(gtn_pkg::DIV25_MUL)) >> gtn_pkg::DIV25_SHIFT);
    assign days = DW'(y) * DW'(365) + DW'(q4) - DW'(q100) + DW'(q400);
    assign leap = (y[1:0] == 2'd0)
                  && (((YW+1)'(q400) * (YW+1)'(400) == {1'b0, y})
                      || ((YW+1)'(q100) * (YW+1)'(100) != {1'b0, y}));
endmodule

>>> hdl/gregorian_timestamp_normalizer.sv
// Gregorian timestamp normalizer.
// Pulse start with year_in, month_in, day_in, hour_in and minute_in while
// busy is low; busy is tied low, so an item may be started every cycle.
// Each item yields one result, marked by done for exactly one cycle, with
// the normalized date and time, the day number from the start of year 0,
// and overflow when the year passed YEAR_LIMIT (result then saturates to
// the last minute of YEAR_LIMIT).
// Each item passes through the pipeline stages in order (minute split,
// day sum, year estimate, year correction, month decode); throughput is
// one item per cycle.
// Reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall: results must be taken when done is high.
module gregorian_timestamp_normalizer #(
    parameter int YEAR_LIMIT = 4095
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] year_in,
    input  logic [3:0]  month_in,
    input  logic [4:0]  day_in,
    input  logic [9:0]  hour_in,
    input  logic [19:0] minute_in,
    output logic        done,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [20:0] day_number,
    output logic        overflow
);
    localparam int YW = gtn_pkg::YACC_W;
    localparam int DW = gtn_pkg::DAYS_W;

    function automatic int limit_day_number(input int y);
        int n;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + 334 + 30;
        if ((y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0)))
        begin
            n = n + 1;
        end
        return n;
    endfunction

    localparam logic [16:0] LIM_Y = 17'(YEAR_LIMIT);
    localparam logic [20:0] LIM_N = 21'(limit_day_number(YEAR_LIMIT));

    logic [4:0] v_reg;

    // stage 1: minute split, month wrap
    logic [YW-1:0] s1_year_reg;
    logic [3:0]    s1_month_reg;
    logic [4:0]    s1_day_reg;
    logic [14:0]   s1_th_reg;
    logic [5:0]    s1_min_reg;
    logic [14:0]   mq;

    assign mq = 15'((37'(minute_in[19:2]) * 37'(gtn_pkg::DIV15_MUL)) >> gtn_pkg::DIV15_SHIFT);

    always_ff @(posedge clk)
    begin
        if (month_in >= gtn_pkg::MONTHS_PER_YEAR)
        begin
            s1_month_reg <= month_in - gtn_pkg::MONTHS_PER_YEAR;
            s1_year_reg  <= YW'(year_in) + YW'(1);
        end
        else
        begin
            s1_month_reg <= month_in;
            s1_year_reg  <= YW'(year_in);
        end
        s1_day_reg <= day_in;
        s1_th_reg  <= 15'(hour_in) + mq;
        s1_min_reg <= 6'(minute_in - 20'(mq) * 20'd60);
    end

    // stage 2: day number
    logic [DW-1:0] dby1;
    logic          leap1;
    logic [DW-1:0] s2_n_reg;
    logic [4:0]    s2_hour_reg;
    logic [5:0]    s2_min_reg;
    logic [14:0]   hq;

    gtn_days_before u_db1 (.y(s1_year_reg), .days(dby1), .leap(leap1));

    assign hq = 15'((24'(s1_th_reg[14:3]) * 24'(gtn_pkg::DIV3_MUL)) >> gtn_pkg::DIV3_SHIFT);

    always_ff @(posedge clk)
    begin
        s2_n_reg    <= dby1 + DW'(gtn_pkg::month_start(s1_month_reg, leap1))
                       + DW'(s1_day_reg) + DW'(hq);
        s2_hour_reg <= 5'(s1_th_reg - hq * 15'd24);
        s2_min_reg  <= s1_min_reg;
    end

    // stage 3: year estimate, rounded so it is the year or the one after
    logic [37:0]   est;
    logic [YW-1:0] s3_ye_reg;
    logic [DW-1:0] s3_n_reg;
    logic [4:0]    s3_hour_reg;
    logic [5:0]    s3_min_reg;

    assign est = 38'(s2_n_reg) * 38'(gtn_pkg::EST_MUL)
                 + (38'(1) << (gtn_pkg::EST_SHIFT - 1));

    always_ff @(posedge clk)
    begin
        s3_ye_reg   <= YW'(est >> gtn_pkg::EST_SHIFT);
        s3_n_reg    <= s2_n_reg;
        s3_hour_reg <= s2_hour_reg;
        s3_min_reg  <= s2_min_reg;
    end

    // stage 4: year correction
    logic [YW-1:0] yem;
    logic [DW-1:0] dbe;
    logic [DW-1:0] dbem;
    logic          lpe;
    logic          lpem;
    logic [YW-1:0] s4_y_reg;
    logic [DW-1:0] s4_n_reg;
    logic [DW-1:0] s4_db_reg;
    logic          s4_leap_reg;
    logic [4:0]    s4_hour_reg;
    logic [5:0]    s4_min_reg;

    assign yem = s3_ye_reg - YW'(1);

    gtn_days_before u_dbe (.y(s3_ye_reg), .days(dbe), .leap(lpe));
    gtn_days_before u_dbem (.y(yem), .days(dbem), .leap(lpem));

    always_ff @(posedge clk)
    begin
        if (dbe <= s3_n_reg)
        begin
            s4_y_reg    <= s3_ye_reg;
            s4_db_reg   <= dbe;
            s4_leap_reg <= lpe;
        end
        else
        begin
            s4_y_reg    <= yem;
            s4_db_reg   <= dbem;
            s4_leap_reg <= lpem;
        end
        s4_n_reg    <= s3_n_reg;
        s4_hour_reg <= s3_hour_reg;
        s4_min_reg  <= s3_min_reg;
    end

    // stage 5: month decode, saturation
    logic [8:0]  doy;
    logic [3:0]  mo;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [20:0] dnum_reg;
    logic        ovf_reg;

    assign doy = 9'(s4_n_reg - s4_db_reg);

    always_comb
    begin
        mo = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy >= gtn_pkg::month_start(4'(i), s4_leap_reg))
            begin
                mo = 4'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (17'(s4_y_reg) > LIM_Y)
        begin
            ovf_reg    <= 1'b1;
            year_reg   <= 12'(YEAR_LIMIT);
            month_reg  <= 4'd11;
            day_reg    <= 5'd30;
            hour_reg   <= 5'd23;
            minute_reg <= 6'd59;
            dnum_reg   <= LIM_N;
        end
        else
        begin
            ovf_reg    <= 1'b0;
            year_reg   <= 12'(s4_y_reg);
            month_reg  <= mo;
            day_reg    <= 5'(doy - gtn_pkg::month_start(mo, s4_leap_reg));
            hour_reg   <= s4_hour_reg;
            minute_reg <= s4_min_reg;
            dnum_reg   <= 21'(s4_n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 5'd0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], start};
        end
    end

    assign busy       = 1'b0;
    assign done       = v_reg[4];
    assign year_out   = year_reg;
    assign month_out  = month_reg;
    assign day_out    = day_reg;
    assign hour_out   = hour_reg;
    assign minute_out = minute_reg;
    assign day_number = dnum_reg;
    assign overflow   = ovf_reg;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done) else $error("lost item");
    a_hr: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hour_out < 5'd24 && minute_out < 6'd60) else $error("time range");
    a_ov: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> month_out == 4'd11 && day_out == 5'd30)
        else $error("saturation");
endmodule
